/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Operation codes on the input channel.
  localparam logic [1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [1:0] OP_DEQUEUE  = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;

  // Status codes on the output channel.
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REMOVED  = 3'd1;
  localparam logic [2:0] ST_LISTED   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_cmd_t;

  // What one cell shows to its neighbours.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } cell_link_t;

endpackage

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and moves it to a neighbour.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::cell_cmd_t               cmd,
  input  logic signed [spq_pkg::DATA_W-1:0] new_data,
  input  logic signed [spq_pkg::DATA_W-1:0] new_prio,
  input  logic signed [spq_pkg::DATA_W-1:0] head_data,
  input  logic signed [spq_pkg::DATA_W-1:0] head_prio,
  input  spq_pkg::cell_link_t              left,
  input  spq_pkg::cell_link_t              right,
  output spq_pkg::cell_link_t              self
);

  logic                             valid;
  logic signed [spq_pkg::DATA_W-1:0] data;
  logic signed [spq_pkg::DATA_W-1:0] prio;
  logic                             gt;
  logic                             take_new;

  // The new entry goes behind every entry of lower or equal priority.
  assign gt       = valid && (prio > new_prio);
  assign take_new = (gt || !valid) && left.valid && !left.gt;

  assign self.valid = valid;
  assign self.gt    = gt;
  assign self.data  = data;
  assign self.prio  = prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        spq_pkg::CELL_INSERT: begin
          if (left.gt) begin
            data  <= left.data;
            prio  <= left.prio;
            valid <= 1'b1;
          end else if (take_new) begin
            data  <= new_data;
            prio  <= new_prio;
            valid <= 1'b1;
          end
        end
        spq_pkg::CELL_REMOVE: begin
          data  <= right.data;
          prio  <= right.prio;
          valid <= right.valid;
        end
        spq_pkg::CELL_ROTATE: begin
          // The tail cell takes the head so the list comes back in order.
          if (right.valid) begin
            data <= right.data;
            prio <= right.prio;
          end else if (valid) begin
            data <= head_data;
            prio <= head_prio;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// The input channel carries one command beat: op selects enqueue, dequeue of
// the head or a traverse of all entries; item_data and item_priority are used
// by an enqueue only. Op code 3 is dropped without a result.
// The output channel carries result beats with status, out_data and last;
// last marks the final beat caused by one command.
// A command beat is held in an input register and is worked on once the
// output register is free, which then takes its first result. The input
// register stands busy while it holds a command, so a new command is taken
// only after the current one has been worked on. A traverse first sets up
// its count of entries and then, while the receiver does not stall, gives
// one beat per cycle for every stored entry; the chain rotates by one place
// per listed beat and is back in its original order at the end.
// The output register holds a finished beat while the receiver stalls, and a
// further command is still taken into the input register meanwhile; work on
// it waits until the output register is free.
// Reset empties the queue and drops any command or result in flight.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic signed [spq_pkg::DATA_W-1:0] item_data,
  input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic signed [spq_pkg::DATA_W-1:0] out_data,
  output logic                             last
);

  typedef enum logic {
    IDLE,
    LIST
  } state_t;

  state_t                           state;
  logic                             in_reg_valid;
  logic [1:0]                       in_op;
  logic signed [spq_pkg::DATA_W-1:0] in_data;
  logic signed [spq_pkg::DATA_W-1:0] in_prio;
  logic [spq_pkg::CNT_W-1:0]        occupancy;
  logic [spq_pkg::CNT_W-1:0]        remaining;

  spq_pkg::cell_cmd_t  cell_cmd;
  spq_pkg::cell_link_t link [spq_pkg::DEPTH];
  spq_pkg::cell_link_t sentinel;
  spq_pkg::cell_link_t tail_end;

  logic slot_free;
  logic go;
  logic full;
  logic empty;
  logic beat_out;

  assign in_stall  = in_reg_valid;
  assign slot_free = !out_valid || !out_stall;
  assign go        = (state == IDLE) && in_reg_valid && slot_free;
  assign full      = link[spq_pkg::DEPTH-1].valid;
  assign empty     = !link[0].valid;

  // Left of the head sits a filled slot that never outranks the new entry,
  // and right of the tail an empty one.
  always_comb begin
    sentinel       = '0;
    sentinel.valid = 1'b1;
    tail_end       = '0;
  end

  always_comb begin
    cell_cmd = spq_pkg::CELL_HOLD;
    if (go) begin
      if (in_op == spq_pkg::OP_ENQUEUE && !full) begin
        cell_cmd = spq_pkg::CELL_INSERT;
      end else if (in_op == spq_pkg::OP_DEQUEUE && !empty) begin
        cell_cmd = spq_pkg::CELL_REMOVE;
      end
    end else if (state == LIST && slot_free) begin
      cell_cmd = spq_pkg::CELL_ROTATE;
    end
  end

  // A new beat is loaded into the output register in this cycle.
  always_comb begin
    beat_out = 1'b0;
    if (go) begin
      if (in_op == spq_pkg::OP_ENQUEUE || in_op == spq_pkg::OP_DEQUEUE) begin
        beat_out = 1'b1;
      end else if (in_op == spq_pkg::OP_TRAVERSE) begin
        beat_out = empty;
      end
    end else if (state == LIST && slot_free) begin
      beat_out = 1'b1;
    end
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::cell_link_t left_link;
    spq_pkg::cell_link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = sentinel;
    end else begin : g_mid
      assign left_link = link[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign right_link = tail_end;
    end else begin : g_body
      assign right_link = link[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cell_cmd),
      .new_data  (in_data),
      .new_prio  (in_prio),
      .head_data (link[0].data),
      .head_prio (link[0].prio),
      .left      (left_link),
      .right     (right_link),
      .self      (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
      occupancy    <= '0;
      remaining    <= '0;
    end else begin
      if (beat_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (in_valid && !in_stall) begin
        in_reg_valid <= 1'b1;
        in_op        <= op;
        in_data      <= item_data;
        in_prio      <= item_priority;
      end

      unique case (state)
        IDLE: begin
          if (go) begin
            in_reg_valid <= 1'b0;
            unique case (in_op)
              spq_pkg::OP_ENQUEUE: begin
                out_data  <= '0;
                last      <= 1'b1;
                if (full) begin
                  status <= spq_pkg::ST_FULL;
                end else begin
                  status    <= spq_pkg::ST_ACCEPTED;
                  occupancy <= occupancy + spq_pkg::CNT_W'(1);
                end
              end
              spq_pkg::OP_DEQUEUE: begin
                last      <= 1'b1;
                if (empty) begin
                  status   <= spq_pkg::ST_EMPTY;
                  out_data <= '0;
                end else begin
                  status    <= spq_pkg::ST_REMOVED;
                  out_data  <= link[0].data;
                  occupancy <= occupancy - spq_pkg::CNT_W'(1);
                end
              end
              spq_pkg::OP_TRAVERSE: begin
                if (empty) begin
                  status    <= spq_pkg::ST_EMPTY;
                  out_data  <= '0;
                  last      <= 1'b1;
                end else begin
                  state     <= LIST;
                  remaining <= occupancy;
                end
              end
              default: begin
              end
            endcase
          end
        end
        LIST: begin
          if (slot_free) begin
            status    <= spq_pkg::ST_LISTED;
            out_data  <= link[0].data;
            last      <= (remaining == spq_pkg::CNT_W'(1));
            remaining <= remaining - spq_pkg::CNT_W'(1);
            if (remaining == spq_pkg::CNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the sorted priority queue unit.
// ----------------------------------------------------------------------------
// Commands are driven on the input channel and every accepted beat is passed
// to a scoreboard. The scoreboard holds its own sorted copy of the queue,
// works out the result beats that each command should cause, and compares
// them with the beats the unit delivers.
// A short directed sequence covers the extremes first: empty queue, unused
// op code, equal priorities and a full queue. Bursts of random commands
// follow under three idling regimes, plus one long stall of the output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Op code 3 has no function and must be dropped without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RUN_LIMIT        = 400000;
  localparam int RANDOM_PER_PHASE = 108;
  localparam int SETTLE_CYCLES    = 40;

  typedef struct {
    logic [2:0]                        status;
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic                              last;
  } result_beat_t;

  typedef struct {
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic signed [spq_pkg::DATA_W-1:0] prio;
  } queue_entry_t;

  // The scoreboard keeps the queue contents in order from the head, so that
  // each accepted command can be turned into the beats it should produce.
  class sorted_queue_checker;
    queue_entry_t entries[$];
    result_beat_t awaited[$];
    int unsigned  fail_count;

    function void push_beat(logic [2:0] st, logic signed [spq_pkg::DATA_W-1:0] d,
                            logic l);
      result_beat_t b;
      b.status = st;
      b.data   = d;
      b.last   = l;
      awaited.push_back(b);
    endfunction

    function void note_command(logic [1:0] code, logic signed [spq_pkg::DATA_W-1:0] d,
                               logic signed [spq_pkg::DATA_W-1:0] p);
      queue_entry_t e;
      int           pos;
      case (code)
        spq_pkg::OP_ENQUEUE: begin
          if (entries.size() >= spq_pkg::DEPTH) begin
            push_beat(spq_pkg::ST_FULL, '0, 1'b1);
          end else begin
            // The new word goes behind every entry of equal or smaller priority.
            pos = entries.size();
            for (int i = 0; i < entries.size(); i++) begin
              if (entries[i].prio > p) begin
                pos = i;
                break;
              end
            end
            e.data = d;
            e.prio = p;
            entries.insert(pos, e);
            push_beat(spq_pkg::ST_ACCEPTED, '0, 1'b1);
          end
        end
        spq_pkg::OP_DEQUEUE: begin
          if (entries.size() == 0) begin
            push_beat(spq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            push_beat(spq_pkg::ST_REMOVED, entries[0].data, 1'b1);
            entries.delete(0);
          end
        end
        spq_pkg::OP_TRAVERSE: begin
          if (entries.size() == 0) begin
            push_beat(spq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < entries.size(); i++) begin
              push_beat(spq_pkg::ST_LISTED, entries[i].data, i == entries.size() - 1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      $display("%0t: beat mismatch, %s", $time, what);
      fail_count++;
    endtask

    task check_beat(logic [2:0] st, logic signed [spq_pkg::DATA_W-1:0] d, logic l);
      result_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat status %0d data %0d last %0b", st, d, l));
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        report($sformatf("status %0d, wanted %0d", st, want.status));
      end
      if (d !== want.data) begin
        report($sformatf("out_data %0d, wanted %0d", d, want.data));
      end
      if (l !== want.last) begin
        report($sformatf("last %0b, wanted %0b", l, want.last));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction

    function int stored();
      return entries.size();
    endfunction
  endclass

  logic                              clk           = 1'b0;
  logic                              rst           = 1'b1;
  logic                              in_valid      = 1'b0;
  logic                              in_stall;
  logic [1:0]                        op            = spq_pkg::OP_ENQUEUE;
  logic signed [spq_pkg::DATA_W-1:0] item_data     = '0;
  logic signed [spq_pkg::DATA_W-1:0] item_priority = '0;
  logic                              out_valid;
  logic                              out_stall     = 1'b0;
  logic [2:0]                        status;
  logic signed [spq_pkg::DATA_W-1:0] out_data;
  logic                              last;

  // Idling odds in percent per cycle, changed between phases of the run.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Raised for a long stretch to make the output back up into the input.
  logic        hold_output    = 1'b0;

  sorted_queue_checker board = new();

  always #10 clk = ~clk;

  sorted_priority_queue_unit uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_data      (out_data),
    .last          (last)
  );

  // Both monitors sample at the rising edge, before any of this edge's
  // nonblocking updates land, so they see exactly what the unit saw.
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0) begin
      board.note_command(op, item_data, item_priority);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_beat(status, out_data, last);
    end
  end

  // The receiving side stalls at random, or solidly while a hold is running.
  always @(posedge clk) begin
    out_stall <= hold_output || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offers one command beat, after a random number of idle cycles, and
  // returns at the edge where it is taken. Valid is left high; the caller
  // either offers the next beat or lowers it.
  task send_beat(logic [1:0] code, logic signed [spq_pkg::DATA_W-1:0] d,
                 logic signed [spq_pkg::DATA_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= code;
    item_data     <= d;
    item_priority <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stops offering and waits until every predicted beat has arrived. The
  // first edge lets the monitor note the beat that has just been taken.
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Holds the output off for a fixed number of cycles in a process of its
  // own, so that the sender carries on meanwhile.
  task hold_receiver(int unsigned cycles);
    fork
      begin
        hold_output <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_output <= 1'b0;
      end
    join_none
  endtask

  function automatic logic signed [spq_pkg::DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_data();
    if ($urandom_range(0, 9) == 0) begin
      return extreme_word();
    end
    return $urandom();
  endfunction

  // Priorities are drawn from narrow ranges half of the time so that ties are
  // common and the ordering among equals is exercised, with full-range values
  // and the extremes mixed in.
  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0:       return extreme_word();
      1, 2, 3: return $signed($urandom_range(0, 6)) - 3;
      4, 5:    return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom();
    endcase
  endfunction

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  // Random commands in bursts that lean towards filling the queue, towards
  // emptying it, or towards neither, so that both the full and the empty
  // queue are reached time and again. Unused op codes are mixed in but not
  // counted.
  task run_random(int unsigned count);
    int unsigned done_items;
    int unsigned burst_left;
    int unsigned roll;
    burst_kind_t kind;
    logic [1:0]  code;
    done_items = 0;
    burst_left = 0;
    kind       = BURST_MIXED;
    while (done_items < count) begin
      if (burst_left == 0) begin
        kind       = burst_kind_t'($urandom_range(0, 2));
        burst_left = $urandom_range(8, 30);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        code = OP_UNUSED;
      end else if (roll < 15) begin
        code = spq_pkg::OP_TRAVERSE;
      end else begin
        case (kind)
          BURST_FILL:  code = (roll < 80) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
          BURST_DRAIN: code = (roll < 30) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
          default:     code = (roll < 57) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
        endcase
      end
      send_beat(code, pick_data(), pick_priority());
      if (code != OP_UNUSED) begin
        done_items++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase one: the sender idles less often than the receiver stalls.
    send_idle_pct  = 26;
    recv_stall_pct = 46;

    // An empty queue answers both a traverse and a dequeue with one empty
    // beat; the unused op code gives nothing at all.
    send_beat(spq_pkg::OP_TRAVERSE, 32'sh1234_5678, 32'sh7654_3210);
    send_beat(spq_pkg::OP_DEQUEUE, '1, '1);
    send_beat(OP_UNUSED, 32'sh5a5a_5a5a, 32'sh0f0f_0f0f);

    // Extreme priorities and data words, then two words of equal priority
    // whose order must follow their arrival.
    send_beat(spq_pkg::OP_ENQUEUE, 32'sh8000_0000, 32'sh7fff_ffff);
    send_beat(spq_pkg::OP_ENQUEUE, 32'sh7fff_ffff, 32'sh8000_0000);
    send_beat(spq_pkg::OP_ENQUEUE, '0, '0);
    send_beat(spq_pkg::OP_ENQUEUE, '1, '0);
    send_beat(spq_pkg::OP_ENQUEUE, 32'sd1, '1);
    send_beat(spq_pkg::OP_TRAVERSE, '0, '0);
    send_beat(spq_pkg::OP_DEQUEUE, '0, '0);

    // Four entries remain, so twelve more fill the queue; the next word is
    // dropped, and the traverse lists a full chain with many ties.
    for (int i = 0; i < 12; i++) begin
      send_beat(spq_pkg::OP_ENQUEUE, $urandom(), $urandom_range(0, 3));
    end
    send_beat(spq_pkg::OP_ENQUEUE, 32'sh0bad_0bad, '0);
    send_beat(spq_pkg::OP_TRAVERSE, '0, '0);

    run_random(RANDOM_PER_PHASE);
    wait_drained();

    // Phase two: the roles swap. It opens with a long hold on the output
    // while the sender keeps offering, so that the unit fills and stalls its
    // input; then the sender waits for the backlog to clear.
    send_idle_pct  = 46;
    recv_stall_pct = 26;
    hold_receiver(150);
    repeat (12) send_beat(spq_pkg::OP_ENQUEUE, pick_data(), pick_priority());
    send_beat(spq_pkg::OP_TRAVERSE, '0, '0);
    wait_drained();

    run_random(RANDOM_PER_PHASE);
    wait_drained();

    // Phase three: neither side idles, so beats run back to back.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    // Anything the unit sends after this point is unexpected and counted.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A hang, or a beat that never arrives, ends the run here.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
